### sv/lsf_pkg.sv
// Shared types and constants for the learning switch forwarding core.
// No dependencies; lsf_cam and the forwarding core top level use this package.
package lsf_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int NUM_PORTS_DEF   = 8;

  localparam int TAG_W  = 16;
  localparam int PORT_W = 3;
  localparam int ADDR_W = 48;
  localparam int MASK_W = 8;

  // One frame header as it enters the block.
  typedef struct packed {
    logic [TAG_W-1:0]  frame_tag;
    logic [PORT_W-1:0] arrival_port;
    logic [ADDR_W-1:0] source_address;
    logic [ADDR_W-1:0] dest_address;
  } header_t;

  // One forwarding decision as it leaves the block.
  typedef struct packed {
    logic [TAG_W-1:0]  out_tag;
    logic [MASK_W-1:0] port_mask;
    logic              flooded;
    logic              learned;
    logic              table_full;
  } result_t;

  // Lookup outcome handed from the address table to the top level.
  typedef struct packed {
    logic              dst_hit;
    logic [PORT_W-1:0] dst_port;
    logic              learned;
    logic              table_full;
  } lookup_t;

endpackage

### sv/lsf_stream_if.sv
// Valid/ready stream interface carrying one word of a chosen payload type.
// Used for both channels of the forwarding core; depends on nothing else.
interface lsf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### sv/lsf_cam.sv
// Address-to-port table with parallel exact-match lookup and in-order learning.
// Depends on lsf_pkg for field widths and the lookup result struct.
module lsf_cam #(
  parameter int TABLE_DEPTH = lsf_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        commit,
  input  logic [lsf_pkg::PORT_W-1:0]  arrival_port,
  input  logic [lsf_pkg::ADDR_W-1:0]  source_address,
  input  logic [lsf_pkg::ADDR_W-1:0]  dest_address,
  output lsf_pkg::lookup_t            lookup
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [lsf_pkg::ADDR_W-1:0] entry_address [TABLE_DEPTH];
  logic [lsf_pkg::PORT_W-1:0] entry_port    [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]     entry_valid;
  logic [CNT_W-1:0]           fill_count;

  logic [TABLE_DEPTH-1:0]     src_match;
  logic [TABLE_DEPTH-1:0]     dst_match;
  logic [lsf_pkg::PORT_W-1:0] table_port;
  logic                       src_hit;
  logic                       has_room;
  logic                       learn;
  logic                       self_dst;
  logic [IDX_W-1:0]           wr_idx;

  always_comb begin
    table_port = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      src_match[i] = entry_valid[i] && (entry_address[i] == source_address);
      dst_match[i] = entry_valid[i] && (entry_address[i] == dest_address);
      // Sources are stored only once, so at most one entry matches.
      table_port = table_port | ({lsf_pkg::PORT_W{dst_match[i]}} & entry_port[i]);
    end
  end

  assign src_hit  = |src_match;
  assign has_room = (fill_count < CNT_W'(TABLE_DEPTH));
  assign learn    = !src_hit && has_room;
  assign wr_idx   = fill_count[IDX_W-1:0];

  // A source learned by this same frame is visible to its own destination lookup.
  assign self_dst = learn && (dest_address == source_address);

  always_comb begin
    lookup.dst_hit    = (|dst_match) || self_dst;
    lookup.dst_port   = self_dst ? arrival_port : table_port;
    lookup.learned    = learn;
    lookup.table_full = !src_hit && !has_room;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      fill_count  <= '0;
    end else if (commit && learn) begin
      entry_valid[wr_idx] <= 1'b1;
      fill_count          <= fill_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (commit && learn) begin
      entry_address[wr_idx] <= source_address;
      entry_port[wr_idx]    <= arrival_port;
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(TABLE_DEPTH))
    else $error("fill count ran past the table depth");

  a_src_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(src_match))
    else $error("source address matched more than one entry");

  a_learn_counts: assert property (@(posedge clk) disable iff (rst)
    commit && learn |=> fill_count == $past(fill_count) + CNT_W'(1))
    else $error("learning did not advance the fill count");

endmodule

### sv/learning_switch_forward_core.sv
// Learning switch forwarding core: usage notes below.
// Depends on lsf_pkg, lsf_stream_if and lsf_cam.
//
// The header channel takes one frame header per word (tag, arrival port,
// source and destination address); the verdict channel returns one word per
// header with the tag, the egress port mask and the flooded, learned and
// table_full flags. Both channels use valid/ready; a word moves when both
// are high at a rising clock edge.
// A header is captured in an input register; while it is held there the address
// table compares it against every stored entry at once, learns the source if
// it is new and there is room, and the verdict is registered once the output
// register is free or its word is being taken. One header is accepted every
// cycle while the verdict receiver keeps taking words; the combinational
// parallel compare over the table allows that rate. Learning takes effect at
// the edge that registers the verdict, so the very next header already sees it.
// Reset (rst, synchronous) empties the table and both registers.
// If the verdict receiver stalls, the held verdict and the captured header
// stay put, and with a header captured header ready drops until the verdict is taken.
module learning_switch_forward_core #(
  parameter int TABLE_DEPTH = lsf_pkg::TABLE_DEPTH_DEF,
  parameter int NUM_PORTS   = lsf_pkg::NUM_PORTS_DEF
) (
  input logic          clk,
  input logic          rst,
  lsf_stream_if.sink   header,
  lsf_stream_if.source verdict
);

  localparam logic [lsf_pkg::MASK_W-1:0] PORTS_ALL =
    lsf_pkg::MASK_W'((1 << NUM_PORTS) - 1);

  lsf_pkg::header_t hdr;
  logic             hdr_valid;
  lsf_pkg::result_t res;
  lsf_pkg::result_t res_next;
  logic             res_valid;
  logic             advance;
  lsf_pkg::lookup_t lookup;

  assign advance       = hdr_valid && (!res_valid || verdict.ready);
  assign header.ready  = !hdr_valid || advance;
  assign verdict.valid = res_valid;
  assign verdict.payload = res;

  lsf_cam #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_cam (
    .clk            (clk),
    .rst            (rst),
    .commit         (advance),
    .arrival_port   (hdr.arrival_port),
    .source_address (hdr.source_address),
    .dest_address   (hdr.dest_address),
    .lookup         (lookup)
  );

  always_comb begin
    res_next.out_tag    = hdr.frame_tag;
    res_next.flooded    = !lookup.dst_hit;
    res_next.learned    = lookup.learned;
    res_next.table_full = lookup.table_full;
    if (lookup.dst_hit) begin
      // A learned port outside the configured range drops the frame.
      res_next.port_mask = (lsf_pkg::MASK_W'(1) << lookup.dst_port) & PORTS_ALL;
    end else begin
      res_next.port_mask = PORTS_ALL & ~(lsf_pkg::MASK_W'(1) << hdr.arrival_port);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (header.ready) begin
        hdr_valid <= header.valid;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (verdict.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (header.valid && header.ready) begin
      hdr <= header.payload;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  a_hit_single_port: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.flooded |-> $onehot0(res.port_mask))
    else $error("forwarded verdict names more than one port");

  a_learn_excl_full: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.learned && res.table_full))
    else $error("verdict is both learned and table full");

  a_hdr_holds: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && !advance |=> hdr_valid && $stable(hdr))
    else $error("captured header changed while its verdict was blocked");

endmodule

### tb/lsf_forward_check.sv
`timescale 1ns / 100ps
// Forwarding core checker: watches the header and verdict channels, keeps its
// own copy of the station table and compares each verdict word with the
// predicted one. Depends on lsf_pkg.
module lsf_forward_check #(
  parameter int TABLE_DEPTH = lsf_pkg::TABLE_DEPTH_DEF,
  parameter int NUM_PORTS   = lsf_pkg::NUM_PORTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             hdr_valid,
  input  logic             hdr_ready,
  input  lsf_pkg::header_t hdr_word,
  input  logic             vd_valid,
  input  logic             vd_ready,
  input  lsf_pkg::result_t vd_word,
  output int               outstanding,
  output int               fail_count
);

  localparam logic [lsf_pkg::MASK_W-1:0] ALL_PORTS =
    lsf_pkg::MASK_W'((1 << NUM_PORTS) - 1);

  logic [lsf_pkg::ADDR_W-1:0] station_addr [TABLE_DEPTH];
  logic [lsf_pkg::PORT_W-1:0] station_port [TABLE_DEPTH];
  bit                         station_valid [TABLE_DEPTH];
  int                         stations_used;
  lsf_pkg::result_t           pending_verdicts [$];
  int                         errors;

  initial begin
    errors = 0;
    stations_used = 0;
  end

  function automatic bit find_station(input logic [lsf_pkg::ADDR_W-1:0] addr,
                                      output int idx);
    idx = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (station_valid[i] && station_addr[i] == addr) begin
        idx = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Learning comes first, so a header whose source equals its destination
  // already hits the entry it has just created.
  function automatic lsf_pkg::result_t forward_decision(input lsf_pkg::header_t h);
    lsf_pkg::result_t r;
    int               idx;
    r = '0;
    r.out_tag = h.frame_tag;
    if (!find_station(h.source_address, idx)) begin
      if (stations_used < TABLE_DEPTH) begin
        station_addr[stations_used]  = h.source_address;
        station_port[stations_used]  = h.arrival_port;
        station_valid[stations_used] = 1'b1;
        stations_used++;
        r.learned = 1'b1;
      end else begin
        r.table_full = 1'b1;
      end
    end
    if (find_station(h.dest_address, idx)) begin
      // A station learned on a port the switch does not have gets nothing.
      if (int'(station_port[idx]) < NUM_PORTS) begin
        r.port_mask = lsf_pkg::MASK_W'(1) << station_port[idx];
      end
    end else begin
      r.flooded   = 1'b1;
      r.port_mask = ALL_PORTS & ~(lsf_pkg::MASK_W'(1) << h.arrival_port);
    end
    return r;
  endfunction

  task automatic compare_verdict(input lsf_pkg::result_t want,
                                 input lsf_pkg::result_t got);
    if (got.out_tag !== want.out_tag) begin
      $error("out_tag: expected %h, got %h", want.out_tag, got.out_tag);
      errors++;
    end
    if (got.port_mask !== want.port_mask) begin
      $error("port_mask: expected %h, got %h", want.port_mask, got.port_mask);
      errors++;
    end
    if (got.flooded !== want.flooded) begin
      $error("flooded: expected %b, got %b", want.flooded, got.flooded);
      errors++;
    end
    if (got.learned !== want.learned) begin
      $error("learned: expected %b, got %b", want.learned, got.learned);
      errors++;
    end
    if (got.table_full !== want.table_full) begin
      $error("table_full: expected %b, got %b", want.table_full, got.table_full);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pending_verdicts.delete();
      for (int i = 0; i < TABLE_DEPTH; i++) station_valid[i] = 1'b0;
      stations_used = 0;
    end else begin
      // The verdict leaving now always belongs to an earlier header, so it is
      // checked before the header taken at this edge is queued.
      if (vd_valid && vd_ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("verdict word with tag %h arrived with none expected", vd_word.out_tag);
          errors++;
        end else begin
          compare_verdict(pending_verdicts.pop_front(), vd_word);
        end
      end
      if (hdr_valid && hdr_ready) begin
        pending_verdicts = {pending_verdicts, forward_decision(hdr_word)};
      end
    end
    outstanding <= pending_verdicts.size();
    fail_count  <= errors;
  end

endmodule

### tb/learning_switch_forward_core_test.sv
`timescale 1ns / 100ps
// Top of the forwarding core testbench: clock, reset, header stimulus and verdict
// back-pressure. Depends on the core, lsf_pkg, lsf_stream_if, lsf_forward_check.
module learning_switch_forward_core_test;

  localparam int POOL_SIZE    = 24;
  localparam int RANDOM_ITEMS = 700;

  logic clk;
  logic rst;
  int   outstanding;
  int   fail_count;

  logic [lsf_pkg::ADDR_W-1:0] station_pool [POOL_SIZE];

  lsf_stream_if #(.payload_t(lsf_pkg::header_t)) header_ch ();
  lsf_stream_if #(.payload_t(lsf_pkg::result_t)) verdict_ch ();

  learning_switch_forward_core DUT (
    .clk     (clk),
    .rst     (rst),
    .header  (header_ch),
    .verdict (verdict_ch)
  );

  lsf_forward_check u_check (
    .clk         (clk),
    .rst         (rst),
    .hdr_valid   (header_ch.valid),
    .hdr_ready   (header_ch.ready),
    .hdr_word    (header_ch.payload),
    .vd_valid    (verdict_ch.valid),
    .vd_ready    (verdict_ch.ready),
    .vd_word     (verdict_ch.payload),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic lsf_pkg::header_t make_header(
    input logic [lsf_pkg::TAG_W-1:0]  tag,
    input logic [lsf_pkg::PORT_W-1:0] port,
    input logic [lsf_pkg::ADDR_W-1:0] src,
    input logic [lsf_pkg::ADDR_W-1:0] dst);
    lsf_pkg::header_t h;
    h.frame_tag      = tag;
    h.arrival_port   = port;
    h.source_address = src;
    h.dest_address   = dst;
    return h;
  endfunction

  // Sources mostly come from the pool, whose upper part can never be learned
  // once the table is full; destinations mix pool hits, self-addressed frames
  // and unknown stations.
  function automatic lsf_pkg::header_t random_header();
    lsf_pkg::header_t h;
    int               pick;
    h.frame_tag    = lsf_pkg::TAG_W'($urandom);
    h.arrival_port = lsf_pkg::PORT_W'($urandom_range(0, 7));
    pick = $urandom_range(0, 9);
    if (pick < 8) h.source_address = station_pool[$urandom_range(0, POOL_SIZE - 1)];
    else h.source_address = lsf_pkg::ADDR_W'({$urandom, $urandom});
    pick = $urandom_range(0, 9);
    if (pick < 5) h.dest_address = station_pool[$urandom_range(0, POOL_SIZE - 1)];
    else if (pick < 7) h.dest_address = h.source_address;
    else h.dest_address = lsf_pkg::ADDR_W'({$urandom, $urandom});
    return h;
  endfunction

  // Offers one word and returns at the edge where it is taken.
  task automatic push_header(input lsf_pkg::header_t h);
    header_ch.valid   <= 1'b1;
    header_ch.payload <= h;
    @(posedge clk);
    while (!header_ch.ready) @(posedge clk);
  endtask

  task automatic idle_header(input int cycles);
    header_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    int sent;
    int burst;
    int gap;
    rst               <= 1'b1;
    header_ch.valid   <= 1'b0;
    header_ch.payload <= '0;
    station_pool[0] = '0;
    station_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      station_pool[i] = lsf_pkg::ADDR_W'({$urandom, $urandom});
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part: address extremes, a known source on a new port, frames
    // sent to themselves, filling the table, then unknown sources once full.
    push_header(make_header(16'h0000, 3'd0, station_pool[0], station_pool[1]));
    push_header(make_header(16'hFFFF, 3'd7, station_pool[1], station_pool[0]));
    push_header(make_header(16'h0001, 3'd3, station_pool[0], station_pool[0]));
    for (int i = 2; i < 16; i++) begin
      push_header(make_header(lsf_pkg::TAG_W'($urandom), lsf_pkg::PORT_W'(i),
                              station_pool[i],
                              (i % 2 == 0) ? station_pool[i] : station_pool[i - 1]));
    end
    push_header(make_header(16'h5A5A, 3'd4, station_pool[16], station_pool[16]));
    push_header(make_header(16'hA5A5, 3'd2, station_pool[17], station_pool[1]));

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        push_header(random_header());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) idle_header(gap);
    end
    header_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("learning_switch_forward_core verification clean");
    end else begin
      $display("learning_switch_forward_core verification failed");
    end
    $finish;
  end

  // Verdict side: a stall pattern that is redrawn from four modes, plus two long
  // hold-offs during which the header side keeps offering and backs up.
  initial begin
    int cycle;
    int mode;
    cycle = 0;
    mode  = 0;
    verdict_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle % 64 == 0) mode = $urandom_range(0, 3);
      if ((cycle >= 200 && cycle < 260) || (cycle >= 900 && cycle < 960)) begin
        verdict_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: verdict_ch.ready <= 1'b1;
          1: verdict_ch.ready <= 1'($urandom_range(0, 1));
          2: verdict_ch.ready <= ($urandom_range(0, 3) == 0);
          default: verdict_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  initial begin
    #5_000_000;
    $display("learning_switch_forward_core verification failed");
    $finish;
  end

endmodule

### learning_switch_forward_core.f
sv/lsf_pkg.sv
sv/lsf_stream_if.sv
sv/lsf_cam.sv
sv/learning_switch_forward_core.sv
tb/lsf_forward_check.sv
tb/learning_switch_forward_core_test.sv
